/* rtl/mmfp_pkg.sv */
package mmfp_pkg;

  // parser sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAT,
    ST_DATA1,
    ST_DATA2,
    ST_DONE
  } mmfp_state_t;

  // item kind on in_tuser
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 5;
  localparam int CHAN_W    = 4;
  localparam int PEND_W    = 6;
  localparam int OUT_W     = 40;
  localparam int LEN_W     = 2;

  localparam logic [BYTE_W-1:0] STATUS_BIT = 8'h80;
  localparam logic [3:0]        SYS_NIB    = 4'hF;
  localparam logic [CMD_W-1:0]  SYS_BASE   = 5'h08;

  // status byte to command code
  function automatic logic [CMD_W-1:0] decode_cmd(input logic [BYTE_W-1:0] status);
    if (status[7:4] != SYS_NIB) begin
      decode_cmd = {2'b00, status[6:4]};
    end else begin
      decode_cmd = {1'b0, status[3:0]} + SYS_BASE;
    end
  endfunction

  // number of data bytes that follow each command
  function automatic logic [LEN_W-1:0] msg_len(input logic [CMD_W-1:0] cmd);
    case (cmd)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd6: msg_len = 2'd2;
      5'd4, 5'd5, 5'd8, 5'd9, 5'd11: msg_len = 2'd1;
      5'd10: msg_len = 2'd2;
      default: msg_len = 2'd0;
    endcase
  endfunction

endpackage

/* rtl/mmfp_ram.sv */
module mmfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/midi_message_fifo_parser.sv */
// sequence: a push writes the ring (unless full) and goes straight to ST_DONE; a pop on an empty
// ring does the same, else it reads the head in ST_STAT, discards leading data bytes there one
// by one, then reads the data bytes in ST_DATA1 and ST_DATA2 as the message length needs; ST_DONE
// waits while the output register is busy. throughput: one item at a time, the ring ram read
// port giving one byte per cycle
// a new item is taken while the previous result still waits on out_tready
// reset (rst_n low, synchronous): pointers and count go to zero, ring contents are kept
module midi_message_fifo_parser #(
  parameter int RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_in[7:0]
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // message_valid[0], command[5:1], channel[9:6],
                                  // data_first[17:10], data_second[25:18],
                                  // bytes_pending[31:26], push_dropped[32], zero[39:33]
);
  import mmfp_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(RING_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  mmfp_state_t       state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [CMD_W-1:0]  res_cmd_r, res_cmd_nxt;
  logic [CHAN_W-1:0] res_chan_r, res_chan_nxt;
  logic [BYTE_W-1:0] res_d1_r, res_d1_nxt;
  logic [BYTE_W-1:0] res_d2_r, res_d2_nxt;
  logic              res_drop_r, res_drop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [CMD_W-1:0]  stat_cmd;
  logic [LEN_W-1:0]  stat_len;

  mmfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat_cmd = decode_cmd(ram_rdata);
  assign stat_len = msg_len(stat_cmd);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer: next state, ring pointers and result fields
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    res_valid_nxt = res_valid_r;
    res_cmd_nxt   = res_cmd_r;
    res_chan_nxt  = res_chan_r;
    res_d1_nxt    = res_d1_r;
    res_d2_nxt    = res_d2_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = rp_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          res_valid_nxt = 1'b0;
          res_cmd_nxt   = '0;
          res_chan_nxt  = '0;
          res_d1_nxt    = '0;
          res_d2_nxt    = '0;
          res_drop_nxt  = 1'b0;
          if (in_tuser == FUNC_PUSH) begin
            // store the beat unless the ring is full
            if (cnt_r == CW'(RING_DEPTH)) begin
              res_drop_nxt = 1'b1;
            end else begin
              ram_we  = 1'b1;
              wp_nxt  = ptr_inc(wp_r);
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = ST_DONE;
          end else if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            // read the head byte
            ram_raddr = rp_r;
            state_nxt = ST_STAT;
          end
        end
      end

      ST_STAT: begin
        if ((ram_rdata & STATUS_BIT) == '0) begin
          // drop a leading data byte and look at the next one
          rp_nxt    = ptr_inc(rp_r);
          cnt_nxt   = cnt_r - 1'b1;
          ram_raddr = ptr_inc(rp_r);
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_DONE;
          end
        end else if (cnt_r > CW'(stat_len)) begin
          res_valid_nxt = 1'b1;
          res_cmd_nxt   = stat_cmd;
          if (stat_cmd < SYS_BASE) begin
            res_chan_nxt = ram_rdata[3:0];
          end
          len_nxt   = stat_len;
          scan_nxt  = ptr_inc(rp_r);
          ram_raddr = ptr_inc(rp_r);
          if (stat_len == '0) begin
            rp_nxt    = ptr_inc(rp_r);
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DATA1;
          end
        end else begin
          // incomplete message stays in the ring
          state_nxt = ST_DONE;
        end
      end

      ST_DATA1: begin
        res_d1_nxt = ram_rdata;
        ram_raddr  = ptr_inc(scan_r);
        if (len_r == 2'd2) begin
          scan_nxt  = ptr_inc(scan_r);
          state_nxt = ST_DATA2;
        end else begin
          rp_nxt    = ptr_inc(scan_r);
          cnt_nxt   = cnt_r - CW'(2);
          state_nxt = ST_DONE;
        end
      end

      ST_DATA2: begin
        res_d2_nxt = ram_rdata;
        rp_nxt     = ptr_inc(scan_r);
        cnt_nxt    = cnt_r - CW'(3);
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, res_drop_r, PEND_W'(cnt_r), res_d2_r, res_d1_r,
                           res_chan_r, res_cmd_r, res_valid_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    len_r       <= len_nxt;
    res_valid_r <= res_valid_nxt;
    res_cmd_r   <= res_cmd_nxt;
    res_chan_r  <= res_chan_nxt;
    res_d1_r    <= res_d1_nxt;
    res_d2_r    <= res_d2_nxt;
    res_drop_r  <= res_drop_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

/* test/midi_message_fifo_parser_tb.sv */
`timescale 1ns / 1ps

module midi_message_fifo_parser_tb;
  import mmfp_pkg::*;

  localparam int RING_DEPTH  = 32;
  localparam int RAND_ITEMS  = 1800;
  localparam int CALM_ITEMS  = 200;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 60;

  // one result beat, unpacked into its fields
  typedef struct packed {
    logic              msg_valid;
    logic [CMD_W-1:0]  command;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] data_first;
    logic [BYTE_W-1:0] data_second;
    logic [PEND_W-1:0] bytes_pending;
    logic              push_dropped;
  } midi_result_t;

  // one row of the directed stimulus table
  typedef struct {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
    int                reps;
    logic              known;
    midi_result_t      want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = FUNC_PUSH;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  midi_message_fifo_parser #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the receive ring
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int                wr_ptr = 0;
  int                rd_ptr = 0;
  int                unread = 0;

  midi_result_t      midi_results_due [$];
  directed_row_t     stim_table [$];
  int                mismatches = 0;
  int                beats_sent = 0;
  logic              bursts_on = 1'b1;
  int                stall_left = 0;

  // status byte to command: system messages sit above the channel types
  function automatic logic [CMD_W-1:0] status_to_cmd(input logic [BYTE_W-1:0] status);
    if (&status[7:4]) begin
      return 5'd8 + {1'b0, status[3:0]};
    end else begin
      return {2'b00, status[6:4]};
    end
  endfunction

  // data bytes that follow each command
  function automatic int data_bytes_for(input logic [CMD_W-1:0] cmd);
    if (cmd < 5'd4 || cmd == 5'd6 || cmd == 5'd10) begin
      return 2;
    end else if (cmd == 5'd4 || cmd == 5'd5 || cmd == 5'd8 || cmd == 5'd9 || cmd == 5'd11) begin
      return 1;
    end else begin
      return 0;
    end
  endfunction

  // advance the shadow ring by one item and give the result it causes
  function automatic midi_result_t parse_ring_item(input logic func,
                                                   input logic [BYTE_W-1:0] rx_byte);
    midi_result_t      r;
    logic [BYTE_W-1:0] status;
    logic [CMD_W-1:0]  cmd;
    int                len;
    r = '0;
    if (func == FUNC_PUSH) begin
      if (unread >= RING_DEPTH) begin
        r.push_dropped = 1'b1;
      end else begin
        ring_mem[wr_ptr] = rx_byte;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        unread++;
      end
    end else begin
      // skip stray data bytes at the head
      while (unread > 0 && !ring_mem[rd_ptr][7]) begin
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        unread--;
      end
      if (unread > 0) begin
        status = ring_mem[rd_ptr];
        cmd = status_to_cmd(status);
        len = data_bytes_for(cmd);
        if (unread - 1 >= len) begin
          r.msg_valid = 1'b1;
          r.command = cmd;
          if (cmd < 5'd8) r.channel = status[3:0];
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          unread--;
          if (len > 0) begin
            r.data_first = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            unread--;
          end
          if (len > 1) begin
            r.data_second = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            unread--;
          end
        end
      end
    end
    r.bytes_pending = unread[PEND_W-1:0];
    return r;
  endfunction

  // data byte, now and then with bit 7 set
  function automatic logic [BYTE_W-1:0] rand_data();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end else begin
      return 8'($urandom_range(0, 127));
    end
  endfunction

  task automatic add_row(input logic func, input logic [BYTE_W-1:0] rx_byte, input int reps,
                         input int known, input int v, input int cmd, input int ch,
                         input int d1, input int d2, input int pend, input int drop);
    directed_row_t row;
    row.func = func;
    row.rx_byte = rx_byte;
    row.reps = reps;
    row.known = known[0];
    row.want = '{v[0], cmd[CMD_W-1:0], ch[CHAN_W-1:0], d1[BYTE_W-1:0], d2[BYTE_W-1:0],
                 pend[PEND_W-1:0], drop[0]};
    stim_table.push_back(row);
  endtask

  // drive one input beat, with an optional gap first
  task automatic send_item(input logic func, input logic [BYTE_W-1:0] rx_byte,
                           input logic has_want, input midi_result_t want);
    midi_result_t got;
    int           gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= rx_byte;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    got = parse_ring_item(func, rx_byte);
    midi_results_due.push_back(has_want ? want : got);
    beats_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (midi_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic note_mismatch(input string fname, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns %s mismatch: expected %0d actual %0d", $time, fname, exp_v, act_v);
    end
  endtask

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expectation
  midi_result_t exp_r;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (midi_results_due.size() == 0) begin
        note_mismatch("unexpected beat", 0, int'(out_tdata[31:0]));
      end else begin
        exp_r = midi_results_due.pop_front();
        if (out_tdata[0] !== exp_r.msg_valid)
          note_mismatch("message_valid", int'(exp_r.msg_valid), int'(out_tdata[0]));
        if (out_tdata[5:1] !== exp_r.command)
          note_mismatch("command", int'(exp_r.command), int'(out_tdata[5:1]));
        if (out_tdata[9:6] !== exp_r.channel)
          note_mismatch("channel", int'(exp_r.channel), int'(out_tdata[9:6]));
        if (out_tdata[17:10] !== exp_r.data_first)
          note_mismatch("data_first", int'(exp_r.data_first), int'(out_tdata[17:10]));
        if (out_tdata[25:18] !== exp_r.data_second)
          note_mismatch("data_second", int'(exp_r.data_second), int'(out_tdata[25:18]));
        if (out_tdata[31:26] !== exp_r.bytes_pending)
          note_mismatch("bytes_pending", int'(exp_r.bytes_pending), int'(out_tdata[31:26]));
        if (out_tdata[32] !== exp_r.push_dropped)
          note_mismatch("push_dropped", int'(exp_r.push_dropped), int'(out_tdata[32]));
        if (out_tdata[39:33] !== 7'd0)
          note_mismatch("pad bits", 0, int'(out_tdata[39:33]));
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("midi_message_fifo_parser verification failed");
    $finish;
  end

  initial begin : stimulus
    directed_row_t     row;
    midi_result_t      none;
    logic [BYTE_W-1:0] st;
    int                n;
    int                scen;
    int                start;
    int                progress;
    logic              paused;
    none = '0;
    paused = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pop on empty ring, byte_in ignored
    add_row(FUNC_POP,  8'hFF, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    // data bytes only, then a pop drops them all
    add_row(FUNC_PUSH, 8'h00, 1, 1, 0, 0, 0, 0, 0, 1, 0);
    add_row(FUNC_PUSH, 8'h7F, 1, 1, 0, 0, 0, 0, 0, 2, 0);
    add_row(FUNC_POP,  8'h00, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    // note on, incomplete then complete
    add_row(FUNC_PUSH, 8'h90, 1, 1, 0, 0, 0, 0, 0, 1, 0);
    add_row(FUNC_PUSH, 8'h3C, 1, 1, 0, 0, 0, 0, 0, 2, 0);
    add_row(FUNC_POP,  8'h00, 1, 1, 0, 0, 0, 0, 0, 2, 0);
    add_row(FUNC_PUSH, 8'h7F, 1, 1, 0, 0, 0, 0, 0, 3, 0);
    add_row(FUNC_POP,  8'h00, 1, 1, 1, 1, 0, 'h3C, 'h7F, 0, 0);
    // leading data byte consumed, short control change left in place
    add_row(FUNC_PUSH, 8'h11, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_PUSH, 8'hB0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POP,  8'h00, 1, 1, 0, 0, 0, 0, 0, 1, 0);
    add_row(FUNC_PUSH, 8'h07, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_PUSH, 8'h40, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POP,  8'h00, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    // highest system code, no data
    add_row(FUNC_PUSH, 8'hFF, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POP,  8'h00, 1, 1, 1, 23, 0, 0, 0, 0, 0);
    // program change on channel 15, data byte with bit 7 set
    add_row(FUNC_PUSH, 8'hCF, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_PUSH, 8'hFF, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POP,  8'h00, 1, 1, 1, 4, 15, 'hFF, 0, 0, 0);
    // song position, two data bytes
    add_row(FUNC_PUSH, 8'hF2, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_PUSH, 8'h01, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_PUSH, 8'h02, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POP,  8'h00, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    // fill the ring, push to full ring, then drain
    add_row(FUNC_PUSH, 8'hF8, RING_DEPTH, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_PUSH, 8'h55, 1, 1, 0, 0, 0, 0, 0, RING_DEPTH, 1);
    add_row(FUNC_POP,  8'h00, 1, 1, 1, 16, 0, 0, 0, RING_DEPTH - 1, 0);
    add_row(FUNC_POP,  8'h00, RING_DEPTH - 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POP,  8'hA5, 1, 1, 0, 0, 0, 0, 0, 0, 0);

    // walk the directed table
    foreach (stim_table[i]) begin
      row = stim_table[i];
      for (int k = 0; k < row.reps; k++) begin
        send_item(row.func, row.rx_byte, row.known && row.reps == 1, row.want);
      end
    end
    hold_until_drained();

    // random traffic, mostly well-formed messages
    start = beats_sent;
    progress = 0;
    while (progress < RAND_ITEMS) begin
      if (progress >= RAND_ITEMS - CALM_ITEMS) begin
        bursts_on = 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        bursts_on = ~bursts_on;
      end
      if (!paused && progress >= RAND_ITEMS / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end
      scen = $urandom_range(0, 99);
      if (scen < 55) begin
        st = 8'h80 | 8'($urandom_range(0, 127));
        n = data_bytes_for(status_to_cmd(st));
        send_item(FUNC_PUSH, st, 1'b0, none);
        repeat (n) send_item(FUNC_PUSH, rand_data(), 1'b0, none);
        if ($urandom_range(0, 2) != 0)
          send_item(FUNC_POP, 8'($urandom_range(0, 255)), 1'b0, none);
      end else if (scen < 65) begin
        // message cut short, unless it takes no data bytes
        st = 8'h80 | 8'($urandom_range(0, 127));
        n = data_bytes_for(status_to_cmd(st));
        send_item(FUNC_PUSH, st, 1'b0, none);
        if (n > 1) send_item(FUNC_PUSH, rand_data(), 1'b0, none);
        send_item(FUNC_POP, 8'($urandom_range(0, 255)), 1'b0, none);
      end else if (scen < 75) begin
        send_item(FUNC_PUSH, 8'($urandom_range(0, 255)), 1'b0, none);
      end else if (scen < 85) begin
        send_item(FUNC_POP, 8'($urandom_range(0, 255)), 1'b0, none);
      end else if (scen < 93) begin
        repeat ($urandom_range(8, 24))
          send_item(FUNC_PUSH, 8'($urandom_range(0, 255)), 1'b0, none);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(FUNC_POP, 8'($urandom_range(0, 255)), 1'b0, none);
      end
      progress = beats_sent - start;
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && midi_results_due.size() == 0) begin
      $display("midi_message_fifo_parser verification clean");
    end else begin
      $display("midi_message_fifo_parser verification failed");
    end
    $finish;
  end

endmodule
